/* rtl/core/tcsf_pkg.sv */
// tcsf_pkg: shared types and constants of the typed call stack block
// command codes, cell tags, error codes, sequencer states and the result struct
// no dependencies
package tcsf_pkg;

   localparam int DEFAULT_STACK_DEPTH = 256;

   localparam int WORD_W      = 64;
   localparam int TAG_W       = 3;
   localparam int CELL_W      = WORD_W + TAG_W;
   localparam int FRAME_CELLS = 6;
   localparam int LINK_SLOT   = 2;

   localparam int REQ_DATA_W = 280;
   localparam int REQ_USER_W = 6;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = TAG_W;

   localparam logic [TAG_W-1:0] TAG_GENERIC = 3'd0;
   localparam logic [TAG_W-1:0] TAG_INT     = 3'd1;
   localparam logic [TAG_W-1:0] TAG_STR     = 3'd4;
   localparam logic [TAG_W-1:0] TAG_REF     = 3'd5;

   typedef enum logic [2:0] {
      CMD_PUSH  = 3'd0,
      CMD_POP   = 3'd1,
      CMD_WRITE = 3'd2,
      CMD_READ  = 3'd3,
      CMD_FPUSH = 3'd4,
      CMD_FPOP  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_OVER  = 2'd1,
      ERR_UNDER = 2'd2,
      ERR_RANGE = 2'd3
   } err_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_WAIT,
      ST_LINK,
      ST_LINK_WAIT,
      ST_TARGET,
      ST_TARGET_WAIT,
      ST_FRAME,
      ST_FPOP_WAIT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_value;
      logic [TAG_W-1:0]  read_type;
      logic [8:0]        stack_depth;
      logic              is_empty;
      err_type           error;
   } result_type;

endpackage

/* rtl/core/tcsf_ram.sv */
// tcsf_ram: generic single-write, single-read memory with registered read data
// no dependencies
module tcsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/tcsf_out.sv */
// tcsf_out: result register between the sequencer and the rsp channel
// depends on tcsf_pkg
module tcsf_out (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        res_valid,
   input  tcsf_pkg::result_type        res_data,
   output logic                        res_ready,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [tcsf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [tcsf_pkg::RSP_USER_W-1:0] rsp_tuser
);

   logic                 valid_ff;
   logic                 valid_in;
   tcsf_pkg::result_type data_ff;
   logic                 load;

   assign res_ready = !valid_ff || rsp_tready;
   assign load      = res_valid && res_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0, data_ff.error, data_ff.is_empty, data_ff.stack_depth,
                        data_ff.read_value};
   assign rsp_tuser  = data_ff.read_type;

endmodule

/* rtl/core/tcsf_seq.sv */
// tcsf_seq: command sequencer, holds top and frame base, drives the cell memory
// depends on tcsf_pkg; the cell memory lives outside and returns registered read data
module tcsf_seq #(
   parameter int STACK_DEPTH = tcsf_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tcsf_pkg::REQ_DATA_W-1:0]     req_data,
   input  logic [tcsf_pkg::REQ_USER_W-1:0]     req_user,
   output logic                                mem_wr_en,
   output logic [$clog2(STACK_DEPTH)-1:0]      mem_wr_addr,
   output logic [tcsf_pkg::CELL_W-1:0]         mem_wr_data,
   output logic                                mem_rd_en,
   output logic [$clog2(STACK_DEPTH)-1:0]      mem_rd_addr,
   input  logic [tcsf_pkg::CELL_W-1:0]         mem_rd_data,
   output logic                                res_valid,
   output tcsf_pkg::result_type                res_data,
   input  logic                                res_ready
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int TW = $clog2(STACK_DEPTH + 1);
   localparam int XW = AW + 9;

   tcsf_pkg::state_type state_ff, state_in;

   tcsf_pkg::cmd_type             cmd_ff, cmd_in;
   logic [tcsf_pkg::WORD_W-1:0]   value_ff, value_in;
   logic [tcsf_pkg::TAG_W-1:0]    vtag_ff, vtag_in;
   logic [7:0]                    offset_ff, offset_in;
   logic [7:0]                    back_ff, back_in;
   logic [tcsf_pkg::WORD_W-1:0]   name_ff, name_in;
   logic [tcsf_pkg::WORD_W-1:0]   ret_ff, ret_in;
   logic [7:0]                    acc_ff, acc_in;
   logic [31:0]                   linst_ff, linst_in;
   logic [31:0]                   alloc_ff, alloc_in;

   logic [TW-1:0]                 top_ff, top_in;
   logic [AW-1:0]                 base_ff, base_in;
   logic [AW-1:0]                 walk_ff, walk_in;
   logic [2:0]                    slot_ff, slot_in;

   logic [tcsf_pkg::WORD_W-1:0]   rvalue_ff, rvalue_in;
   logic [tcsf_pkg::TAG_W-1:0]    rtype_ff, rtype_in;
   tcsf_pkg::err_type             err_ff, err_in;

   // request selector fields, lowest first
   logic [2:0]  f_command;
   logic [2:0]  f_vtag;
   assign f_command = req_user[2:0];
   assign f_vtag    = req_user[5:3];

   logic accept;
   assign accept = req_valid && req_ready;

   // bounds checks, all in one wide enough width
   logic [XW-1:0] top_x, base_x, walk_x, off_x, depth_x;
   logic [XW-1:0] link_idx_x, fpop_idx_x, tgt_x, frame_end_x;
   logic          push_full, frame_no_room, wr_oob, link_bad, fpop_bad, tgt_bad;
   logic [tcsf_pkg::WORD_W-1:0] rd_word;
   logic [tcsf_pkg::WORD_W-1:0] top_w;
   logic          word_bad, word_in_depth;

   assign top_x       = XW'(top_ff);
   assign base_x      = XW'(base_ff);
   assign walk_x      = XW'(walk_ff);
   assign off_x       = XW'(offset_ff);
   assign depth_x     = XW'(STACK_DEPTH);
   assign link_idx_x  = walk_x + XW'(tcsf_pkg::LINK_SLOT);
   assign fpop_idx_x  = base_x + XW'(tcsf_pkg::LINK_SLOT);
   assign tgt_x       = walk_x + off_x;
   assign frame_end_x = top_x + XW'(tcsf_pkg::FRAME_CELLS);

   assign push_full     = top_x >= depth_x;
   assign frame_no_room = frame_end_x > depth_x;
   assign wr_oob        = off_x >= top_x;
   assign link_bad      = link_idx_x >= top_x;
   assign fpop_bad      = fpop_idx_x >= top_x;
   assign tgt_bad       = tgt_x >= top_x;

   assign rd_word       = mem_rd_data[tcsf_pkg::WORD_W-1:0];
   assign top_w         = tcsf_pkg::WORD_W'(top_ff);
   assign word_bad      = rd_word >= top_w;
   assign word_in_depth = rd_word < tcsf_pkg::WORD_W'(STACK_DEPTH);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcsf_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = tcsf_pkg::ST_EXEC;
            end
         end
         tcsf_pkg::ST_EXEC: begin
            state_in = tcsf_pkg::ST_RESULT;
            case (cmd_ff)
               tcsf_pkg::CMD_POP: begin
                  if (top_ff != '0) state_in = tcsf_pkg::ST_POP_WAIT;
               end
               tcsf_pkg::CMD_READ: begin
                  state_in = (back_ff == '0) ? tcsf_pkg::ST_TARGET : tcsf_pkg::ST_LINK;
               end
               tcsf_pkg::CMD_FPUSH: begin
                  if (!frame_no_room) state_in = tcsf_pkg::ST_FRAME;
               end
               tcsf_pkg::CMD_FPOP: begin
                  if (!fpop_bad) state_in = tcsf_pkg::ST_FPOP_WAIT;
               end
               default: ;
            endcase
         end
         tcsf_pkg::ST_POP_WAIT:    state_in = tcsf_pkg::ST_RESULT;
         tcsf_pkg::ST_LINK: begin
            state_in = link_bad ? tcsf_pkg::ST_RESULT : tcsf_pkg::ST_LINK_WAIT;
         end
         tcsf_pkg::ST_LINK_WAIT: begin
            if (word_bad) begin
               state_in = tcsf_pkg::ST_RESULT;
            end else if (back_ff == 8'd1) begin
               state_in = tcsf_pkg::ST_TARGET;
            end else begin
               state_in = tcsf_pkg::ST_LINK;
            end
         end
         tcsf_pkg::ST_TARGET: begin
            state_in = tgt_bad ? tcsf_pkg::ST_RESULT : tcsf_pkg::ST_TARGET_WAIT;
         end
         tcsf_pkg::ST_TARGET_WAIT: state_in = tcsf_pkg::ST_RESULT;
         tcsf_pkg::ST_FRAME: begin
            if (slot_ff == 3'(tcsf_pkg::FRAME_CELLS - 1)) state_in = tcsf_pkg::ST_RESULT;
         end
         tcsf_pkg::ST_FPOP_WAIT:   state_in = tcsf_pkg::ST_RESULT;
         tcsf_pkg::ST_RESULT: begin
            if (res_ready) state_in = tcsf_pkg::ST_IDLE;
         end
         default:                  state_in = tcsf_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cmd_in    = cmd_ff;
      value_in  = value_ff;
      vtag_in   = vtag_ff;
      offset_in = offset_ff;
      back_in   = back_ff;
      name_in   = name_ff;
      ret_in    = ret_ff;
      acc_in    = acc_ff;
      linst_in  = linst_ff;
      alloc_in  = alloc_ff;
      top_in    = top_ff;
      base_in   = base_ff;
      walk_in   = walk_ff;
      slot_in   = slot_ff;
      rvalue_in = rvalue_ff;
      rtype_in  = rtype_ff;
      err_in    = err_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = top_ff[AW-1:0];
      mem_wr_data = {vtag_ff, value_ff};
      mem_rd_en   = 1'b0;
      mem_rd_addr = walk_ff;

      req_ready = 1'b0;
      res_valid = 1'b0;

      unique case (state_ff)
         tcsf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               cmd_in    = tcsf_pkg::cmd_type'(f_command);
               value_in  = req_data[63:0];
               // tags above reference are stored as generic
               vtag_in   = (f_vtag > tcsf_pkg::TAG_REF) ? tcsf_pkg::TAG_GENERIC : f_vtag;
               offset_in = req_data[71:64];
               back_in   = req_data[79:72];
               name_in   = req_data[143:80];
               ret_in    = req_data[207:144];
               acc_in    = req_data[215:208];
               linst_in  = req_data[247:216];
               alloc_in  = req_data[279:248];
            end
         end
         tcsf_pkg::ST_EXEC: begin
            rvalue_in = '0;
            rtype_in  = tcsf_pkg::TAG_GENERIC;
            err_in    = tcsf_pkg::ERR_OK;
            walk_in   = base_ff;
            slot_in   = '0;
            case (cmd_ff)
               tcsf_pkg::CMD_PUSH: begin
                  if (push_full) begin
                     err_in = tcsf_pkg::ERR_OVER;
                  end else begin
                     mem_wr_en = 1'b1;
                     top_in    = top_ff + TW'(1);
                  end
               end
               tcsf_pkg::CMD_POP: begin
                  if (top_ff == '0) begin
                     err_in = tcsf_pkg::ERR_UNDER;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = AW'(top_ff - TW'(1));
                  end
               end
               tcsf_pkg::CMD_WRITE: begin
                  if (wr_oob) begin
                     err_in = tcsf_pkg::ERR_RANGE;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = off_x[AW-1:0];
                  end
               end
               tcsf_pkg::CMD_FPUSH: begin
                  if (frame_no_room) err_in = tcsf_pkg::ERR_OVER;
               end
               tcsf_pkg::CMD_FPOP: begin
                  if (fpop_bad) begin
                     err_in = tcsf_pkg::ERR_UNDER;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = fpop_idx_x[AW-1:0];
                  end
               end
               default: ;
            endcase
         end
         tcsf_pkg::ST_POP_WAIT: begin
            // popped cells need no clearing: every cell at or above top is rewritten first
            rvalue_in = rd_word;
            rtype_in  = mem_rd_data[tcsf_pkg::CELL_W-1:tcsf_pkg::WORD_W];
            top_in    = top_ff - TW'(1);
         end
         tcsf_pkg::ST_LINK: begin
            if (link_bad) begin
               err_in = tcsf_pkg::ERR_RANGE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = link_idx_x[AW-1:0];
            end
         end
         tcsf_pkg::ST_LINK_WAIT: begin
            if (word_bad) begin
               err_in = tcsf_pkg::ERR_RANGE;
            end else begin
               walk_in = rd_word[AW-1:0];
               back_in = back_ff - 8'd1;
            end
         end
         tcsf_pkg::ST_TARGET: begin
            if (tgt_bad) begin
               err_in = tcsf_pkg::ERR_RANGE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = tgt_x[AW-1:0];
            end
         end
         tcsf_pkg::ST_TARGET_WAIT: begin
            rvalue_in = rd_word;
            rtype_in  = mem_rd_data[tcsf_pkg::CELL_W-1:tcsf_pkg::WORD_W];
         end
         tcsf_pkg::ST_FRAME: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(top_x + XW'(slot_ff));
            case (slot_ff)
               3'd0:    mem_wr_data = {tcsf_pkg::TAG_STR, name_ff};
               3'd1:    mem_wr_data = {tcsf_pkg::TAG_STR, ret_ff};
               3'd2:    mem_wr_data = {tcsf_pkg::TAG_REF, tcsf_pkg::WORD_W'(base_ff)};
               3'd3:    mem_wr_data = {tcsf_pkg::TAG_REF, tcsf_pkg::WORD_W'(acc_ff)};
               3'd4:    mem_wr_data = {tcsf_pkg::TAG_INT, {32{linst_ff[31]}}, linst_ff};
               default: mem_wr_data = {tcsf_pkg::TAG_INT, {32{alloc_ff[31]}}, alloc_ff};
            endcase
            slot_in = slot_ff + 3'd1;
            if (slot_ff == 3'(tcsf_pkg::FRAME_CELLS - 1)) begin
               top_in  = TW'(frame_end_x);
               base_in = top_ff[AW-1:0];
            end
         end
         tcsf_pkg::ST_FPOP_WAIT: begin
            top_in  = TW'(base_ff);
            base_in = word_in_depth ? rd_word[AW-1:0] : '0;
         end
         tcsf_pkg::ST_RESULT: begin
            res_valid = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcsf_pkg::ST_IDLE;
         top_ff   <= '0;
         base_ff  <= '0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
         base_ff  <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      value_ff  <= value_in;
      vtag_ff   <= vtag_in;
      offset_ff <= offset_in;
      back_ff   <= back_in;
      name_ff   <= name_in;
      ret_ff    <= ret_in;
      acc_ff    <= acc_in;
      linst_ff  <= linst_in;
      alloc_ff  <= alloc_in;
      walk_ff   <= walk_in;
      slot_ff   <= slot_in;
      rvalue_ff <= rvalue_in;
      rtype_ff  <= rtype_in;
      err_ff    <= err_in;
   end

   assign res_data.read_value  = rvalue_ff;
   assign res_data.read_type   = rtype_ff;
   assign res_data.stack_depth = top_x[8:0];
   assign res_data.is_empty    = (top_ff == '0);
   assign res_data.error       = err_ff;

endmodule

/* rtl/core/typed_call_stack_frames_core.sv */
// typed call stack with frame base: one result item per command item
// accept to rsp_tvalid: exec, result, output register; a good pop or frame pop adds a
// read wait, a good frame push the frame state (one cell write per cycle), a frame
// relative read up to a link and link wait per frame back (one read per link) and target
// and target wait; new items can be taken in the cycle after the result moves on
// reset clears top, base and state; cells at or above top are rewritten before any read
module typed_call_stack_frames_core #(
   parameter int STACK_DEPTH = tcsf_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // value, offset, frames_back, name_handle, return_handle, scope_link,
   // last_instruction, alloc_size
   input  logic [tcsf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command, value_type
   input  logic [tcsf_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // read_value, stack_depth, is_empty, error, zero pad
   output logic [tcsf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // read_type
   output logic [tcsf_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);

   localparam int AW = $clog2(STACK_DEPTH);

   logic                        mem_wr_en;
   logic [AW-1:0]               mem_wr_addr;
   logic [tcsf_pkg::CELL_W-1:0] mem_wr_data;
   logic                        mem_rd_en;
   logic [AW-1:0]               mem_rd_addr;
   logic [tcsf_pkg::CELL_W-1:0] mem_rd_data;
   logic                        res_valid;
   logic                        res_ready;
   tcsf_pkg::result_type        res_data;

   tcsf_ram #(
      .WIDTH(tcsf_pkg::CELL_W),
      .DEPTH(STACK_DEPTH)
   ) u_cells (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   tcsf_seq #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_data   (req_tdata),
      .req_user   (req_tuser),
      .mem_wr_en  (mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data),
      .mem_rd_en  (mem_rd_en),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data),
      .res_valid  (res_valid),
      .res_data   (res_data),
      .res_ready  (res_ready)
   );

   tcsf_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

/* sim/typed_call_stack_frames_core_tb.sv */
// testbench for typed_call_stack_frames_core: directed and random command items checked
// against a behavioral copy of the stack, with idle and stall phases on both channels
// depends on tcsf_pkg and typed_call_stack_frames_core
`timescale 1ns / 100ps

module typed_call_stack_frames_core_tb;
   import tcsf_pkg::*;

   localparam int STACK_CELLS   = DEFAULT_STACK_DEPTH;
   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_OFF_LEN  = 300;
   localparam int DRAIN_CYCLES  = 40;

   // codes the package does not name
   localparam logic [2:0] CMD_BAD_LO = 3'd6;
   localparam logic [2:0] CMD_BAD_HI = 3'd7;
   localparam logic [2:0] TAG_FLOAT  = 3'd2;
   localparam logic [2:0] TAG_CHAR   = 3'd3;
   localparam logic [2:0] TAG_BAD_LO = 3'd6;
   localparam logic [2:0] TAG_BAD_HI = 3'd7;

   typedef struct {
      logic [2:0]         command;
      logic [63:0]        value;
      logic [2:0]         value_type;
      logic [7:0]         offset;
      logic [7:0]         frames_back;
      logic [63:0]        name_handle;
      logic [63:0]        return_handle;
      logic [7:0]         scope_link;
      logic signed [31:0] last_instruction;
      logic signed [31:0] alloc_size;
   } stack_item_type;

   logic                  clock;
   logic                  reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;

   // behavioral copy of the stack
   logic [63:0] cell_word [STACK_CELLS];
   logic [2:0]  cell_tag [STACK_CELLS];
   int unsigned top_cnt;
   int unsigned base_idx;

   result_type  owed_results[$];
   int unsigned fail_count;
   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;
   bit          hold_off_request;
   bit          growing;
   int unsigned edge_linger;

   typed_call_stack_frames_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] rand_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic stack_item_type fresh_item(input logic [2:0] command);
      stack_item_type it;
      it.command          = command;
      it.value            = rand_word();
      it.value_type       = 3'($urandom_range(7));
      it.offset           = 8'($urandom);
      it.frames_back      = 8'($urandom);
      it.name_handle      = rand_word();
      it.return_handle    = rand_word();
      it.scope_link       = 8'($urandom);
      it.last_instruction = $urandom;
      it.alloc_size       = $urandom;
      return it;
   endfunction

   // advances the stack copy by one command and returns the result it owes
   function automatic result_type apply_command(input stack_item_type it);
      result_type  r;
      logic [2:0]  tag;
      logic [63:0] link_word;
      int unsigned walk_base;
      int unsigned link_at;
      int unsigned old_top;
      int          i;
      bit          path_ok;
      r = '0;
      tag = (it.value_type > TAG_REF) ? TAG_GENERIC : it.value_type;
      case (it.command)
         CMD_PUSH: begin
            if (top_cnt >= STACK_CELLS) begin
               r.error = ERR_OVER;
            end else begin
               cell_word[top_cnt] = it.value;
               cell_tag[top_cnt]  = tag;
               top_cnt++;
            end
         end
         CMD_POP: begin
            if (top_cnt == 0) begin
               r.error = ERR_UNDER;
            end else begin
               top_cnt--;
               r.read_value = cell_word[top_cnt];
               r.read_type  = cell_tag[top_cnt];
               cell_word[top_cnt] = '0;
               cell_tag[top_cnt]  = TAG_GENERIC;
            end
         end
         CMD_WRITE: begin
            if (it.offset >= top_cnt) begin
               r.error = ERR_RANGE;
            end else begin
               cell_word[it.offset] = it.value;
               cell_tag[it.offset]  = tag;
            end
         end
         CMD_READ: begin
            walk_base = base_idx;
            path_ok = 1'b1;
            // follow control links, stopping at the first one that leaves the stack
            for (i = 0; i < it.frames_back && path_ok; i++) begin
               link_at = walk_base + LINK_SLOT;
               if (link_at >= top_cnt) begin
                  path_ok = 1'b0;
               end else begin
                  link_word = cell_word[link_at];
                  if (link_word >= top_cnt) path_ok = 1'b0;
                  else walk_base = 32'(link_word);
               end
            end
            if (path_ok && walk_base + it.offset < top_cnt) begin
               r.read_value = cell_word[walk_base + it.offset];
               r.read_type  = cell_tag[walk_base + it.offset];
            end else begin
               r.error = ERR_RANGE;
            end
         end
         CMD_FPUSH: begin
            if (top_cnt + FRAME_CELLS > STACK_CELLS) begin
               r.error = ERR_OVER;
            end else begin
               old_top = top_cnt;
               cell_word[old_top]     = it.name_handle;
               cell_tag[old_top]      = TAG_STR;
               cell_word[old_top + 1] = it.return_handle;
               cell_tag[old_top + 1]  = TAG_STR;
               cell_word[old_top + 2] = 64'(base_idx);
               cell_tag[old_top + 2]  = TAG_REF;
               cell_word[old_top + 3] = {56'd0, it.scope_link};
               cell_tag[old_top + 3]  = TAG_REF;
               cell_word[old_top + 4] = {{32{it.last_instruction[31]}}, it.last_instruction};
               cell_tag[old_top + 4]  = TAG_INT;
               cell_word[old_top + 5] = {{32{it.alloc_size[31]}}, it.alloc_size};
               cell_tag[old_top + 5]  = TAG_INT;
               top_cnt  = old_top + FRAME_CELLS;
               base_idx = old_top;
            end
         end
         CMD_FPOP: begin
            if (base_idx + LINK_SLOT >= top_cnt) begin
               r.error = ERR_UNDER;
            end else begin
               link_word = cell_word[base_idx + LINK_SLOT];
               for (i = base_idx; i < top_cnt; i++) begin
                  cell_word[i] = '0;
                  cell_tag[i]  = TAG_GENERIC;
               end
               top_cnt  = base_idx;
               base_idx = (link_word < STACK_CELLS) ? 32'(link_word) : 0;
            end
         end
         default: ;
      endcase
      r.stack_depth = 9'(top_cnt);
      r.is_empty    = (top_cnt == 0);
      return r;
   endfunction

   task automatic send_item(input stack_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {it.alloc_size, it.last_instruction, it.scope_link,
                    it.return_handle, it.name_handle, it.frames_back, it.offset,
                    it.value};
      req_tuser <= {it.value_type, it.command};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      owed_results.push_back(apply_command(it));
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   initial begin : result_checker
      result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               $error("result item with no command waiting: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = owed_results.pop_front();
               compare_field("read_value", want.read_value, rsp_tdata[63:0]);
               compare_field("read_type", 64'(want.read_type), 64'(rsp_tuser[2:0]));
               compare_field("stack_depth", 64'(want.stack_depth), 64'(rsp_tdata[72:64]));
               compare_field("is_empty", 64'(want.is_empty), 64'(rsp_tdata[73]));
               compare_field("error", 64'(want.error), 64'(rsp_tdata[75:74]));
            end
         end
      end
   end

   initial begin : result_ready
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   // empty-stack errors, field extremes, tag cleanup, link walks and broken links
   task automatic test_directed();
      stack_item_type it;
      it = fresh_item(CMD_POP);
      send_item(it);
      it = fresh_item(CMD_FPOP);
      send_item(it);
      it = fresh_item(CMD_READ);
      it.frames_back = 8'd1;
      it.offset      = 8'd0;
      send_item(it);
      it = fresh_item(CMD_WRITE);
      it.offset = 8'd0;
      send_item(it);
      it = fresh_item(CMD_PUSH);
      it.value      = '1;
      it.value_type = TAG_BAD_HI;
      send_item(it);
      it = fresh_item(CMD_PUSH);
      it.value      = '0;
      it.value_type = TAG_BAD_LO;
      send_item(it);
      it = fresh_item(CMD_FPUSH);
      it.name_handle      = '1;
      it.return_handle    = '0;
      it.scope_link       = 8'hff;
      it.last_instruction = 32'h8000_0000;
      it.alloc_size       = 32'h7fff_ffff;
      send_item(it);
      it = fresh_item(CMD_READ);
      it.frames_back = 8'd0;
      it.offset      = 8'd4;
      send_item(it);
      it.frames_back = 8'd1;
      it.offset      = 8'd0;
      send_item(it);
      // second hop lands on the name handle, which points past the top
      it.frames_back = 8'd2;
      it.offset      = 8'd1;
      send_item(it);
      it.frames_back = 8'hff;
      it.offset      = 8'd0;
      send_item(it);
      it.frames_back = 8'd0;
      it.offset      = 8'hff;
      send_item(it);
      it = fresh_item(CMD_FPUSH);
      it.last_instruction = '0;
      it.alloc_size       = '1;
      send_item(it);
      // corrupt the control link of the inner frame
      it = fresh_item(CMD_WRITE);
      it.offset     = 8'd10;
      it.value      = '1;
      it.value_type = TAG_REF;
      send_item(it);
      it = fresh_item(CMD_PUSH);
      it.value_type = TAG_FLOAT;
      send_item(it);
      it = fresh_item(CMD_WRITE);
      it.offset     = 8'd0;
      it.value      = 64'h41;
      it.value_type = TAG_CHAR;
      send_item(it);
      it.offset = 8'hff;
      send_item(it);
      it = fresh_item(CMD_FPOP);
      send_item(it);
      it = fresh_item(CMD_POP);
      send_item(it);
      it = fresh_item(CMD_READ);
      it.frames_back = 8'd0;
      it.offset      = 8'd0;
      send_item(it);
      it = fresh_item(CMD_FPOP);
      send_item(it);
      it = fresh_item(CMD_BAD_LO);
      send_item(it);
      it = fresh_item(CMD_BAD_HI);
      send_item(it);
      it = fresh_item(CMD_PUSH);
      it.value_type = TAG_STR;
      send_item(it);
   endtask

   // mostly well-formed frame work; the stack is driven to full and back to empty in turns
   function automatic stack_item_type next_random_item();
      stack_item_type it;
      int unsigned    pick;
      pick = $urandom_range(99);
      it = fresh_item(CMD_PUSH);
      if (pick < (growing ? 30 : 10)) begin
         it.command = CMD_FPUSH;
      end else if (pick < (growing ? 65 : 25)) begin
         it.command = CMD_PUSH;
      end else if (pick < (growing ? 78 : 40)) begin
         it.command     = CMD_READ;
         it.frames_back = ($urandom_range(9) != 0) ? 8'($urandom_range(3)) : 8'($urandom);
         it.offset      = ($urandom_range(6) != 0) ? 8'($urandom_range(9)) : 8'($urandom);
      end else if (pick < (growing ? 86 : 48)) begin
         it.command = CMD_WRITE;
         if (top_cnt != 0 && $urandom_range(9) != 0) it.offset = 8'($urandom_range(top_cnt - 1));
      end else if (pick < (growing ? 91 : 68)) begin
         it.command = CMD_POP;
      end else if (pick < (growing ? 94 : 90)) begin
         it.command = CMD_FPOP;
      end else if (pick < 97) begin
         it.command = 3'($urandom_range(7));
      end else begin
         it.command = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
      end
      return it;
   endfunction

   task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
                              input int unsigned count);
      stack_item_type it;
      int unsigned    done_cnt;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      done_cnt = 0;
      while (done_cnt < count) begin
         it = next_random_item();
         send_item(it);
         if (it.command <= CMD_FPOP) done_cnt++;
         // linger near full or empty so the overflow and underflow cases come up
         if (growing ? (top_cnt > STACK_CELLS - FRAME_CELLS) : (top_cnt == 0)) begin
            if (edge_linger == 0) begin
               growing = !growing;
               edge_linger = $urandom_range(8, 20);
            end else begin
               edge_linger--;
            end
         end
      end
   endtask

   // result side holds off while commands keep coming, so the input has to stall
   task automatic test_back_pressure();
      int i;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_request = 1'b1;
      for (i = 0; i < 24; i++) send_item(next_random_item());
   endtask

   initial begin : stimulus
      int i;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      for (i = 0; i < STACK_CELLS; i++) begin
         cell_word[i] = '0;
         cell_tag[i]  = TAG_GENERIC;
      end
      top_cnt          = 0;
      base_idx         = 0;
      fail_count       = 0;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      hold_off_request = 1'b0;
      growing          = 1'b1;
      edge_linger      = $urandom_range(8, 20);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_back_pressure();
      test_random(0, 0, 250);
      test_random(81, 0, 250);
      test_random(0, 81, 250);
      test_random(26, 26, 250);
      req_tvalid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
